// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the filter RTL.
// No dependencies; each user file must have i_clk and i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define ASSERT_CLK(name, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(name, cond, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

`endif

// ===== rtl/bm3_pkg.sv =====
// Shared types and constants of the 3x3 box-mean filter.
// No dependencies.
package bm3_pkg;

    localparam int DATA_W     = 8;
    localparam int ROW_W      = 12;
    localparam int OUT_COL_W  = 10;
    localparam int IMG_W_W    = 11;
    localparam int IMG_H_W    = 13;
    localparam int CFG_W      = 13;
    localparam int CFG_IDX_W  = 4;
    localparam int COLSUM_W   = 10;
    localparam int SUM_W      = 12;
    localparam int RECIP_W    = 13;
    localparam int PROD_W     = SUM_W + RECIP_W;
    localparam int RECIP_SHIFT = 16;

    localparam int DEF_MAX_WIDTH = 1024;
    localparam int MAX_HEIGHT    = 4096;
    localparam int MIN_DIM       = 3;
    localparam int Q_DEPTH       = 8;

    // largest window sum: 9 * 255
    localparam logic [SUM_W-1:0] MAX_SUM = SUM_W'(9 * 255);

    // floor(x / 9) == (x * 7282) >> 16 for x <= 9 * 255
    localparam logic [RECIP_W-1:0] RECIP_9 = RECIP_W'(7282);

    localparam logic [IMG_W_W-1:0] RESET_IMG_WIDTH  = IMG_W_W'(1024);
    localparam logic [IMG_H_W-1:0] RESET_IMG_HEIGHT = IMG_H_W'(1024);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

    typedef struct packed {
        logic [DATA_W-1:0] top;
        logic [DATA_W-1:0] mid;
        logic [DATA_W-1:0] bot;
    } t_column;

    typedef struct packed {
        logic [ROW_W-1:0]     row;
        logic [OUT_COL_W-1:0] col;
        logic [DATA_W-1:0]    value;
        logic                 done;
    } t_result;

    // results caused by one pixel: interior mean first, border copy second
    typedef struct packed {
        logic    int_valid;
        t_result int_res;
        logic    bord_valid;
        t_result bord_res;
    } t_pair;

endpackage

// ===== rtl/bm3_ram.sv =====
// Generic simple dual-port RAM, one write port, one registered read port.
// No dependencies.
module bm3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/bm3_cell.sv =====
// One window cell: holds a 3-pixel column and its sum, passes it on when shifted.
// Depends on bm3_pkg.
module bm3_cell (
    input  logic             i_clk,
    input  logic             i_shift,
    input  bm3_pkg::t_column i_col,
    output bm3_pkg::t_column o_col,
    output logic [bm3_pkg::COLSUM_W-1:0] o_sum
);
    import bm3_pkg::*;

    t_column               r_col;
    logic [COLSUM_W-1:0]   r_sum;
    logic [COLSUM_W-1:0]   n_sum;

    assign n_sum = COLSUM_W'(i_col.top) + COLSUM_W'(i_col.mid) + COLSUM_W'(i_col.bot);

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_col <= i_col;
            r_sum <= n_sum;
        end
    end

    assign o_col = r_col;
    assign o_sum = r_sum;

endmodule

// ===== rtl/bm3_out_queue.sv =====
// Result queue: holds result pairs, hands them out one result per transfer.
// Depends on bm3_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bm3_out_queue #(
    parameter int DEPTH = bm3_pkg::Q_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  bm3_pkg::t_pair   i_pair,
    output logic             o_tvalid,
    input  logic             i_tready,
    output bm3_pkg::t_result o_res,
    output logic             o_pop
);
    import bm3_pkg::*;

    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_pair            r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;
    logic             r_sub,    n_sub;

    t_pair            head;
    logic             take_second;
    logic             xfer;

    assign head        = r_mem[r_rd_ptr];
    assign take_second = r_sub || !head.int_valid;
    assign o_tvalid    = (r_count != '0);
    assign o_res       = take_second ? head.bord_res : head.int_res;
    assign xfer        = o_tvalid && i_tready;
    // entry is freed once its last result leaves
    assign o_pop       = xfer && (take_second || !head.bord_valid);

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        n_sub    = r_sub;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (o_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            n_sub    = 1'b0;
        end else if (xfer) begin
            n_sub    = 1'b1;
        end
        n_count = r_count + CNT_W'(i_push) - CNT_W'(o_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
            r_sub    <= 1'b0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
            r_sub    <= n_sub;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_pair;
        end
    end

    `ASSERT_NEVER(a_q_overflow, i_push && !o_pop && (r_count == CNT_W'(DEPTH)),
        "result queue overflow")
    `ASSERT_CLK(a_q_second_ok, r_sub |-> (o_tvalid && head.int_valid && head.bord_valid),
        "second result selected on an entry without two results")

endmodule

// ===== rtl/box_mean_3x3_image_filter.sv =====
// Top level of the 3x3 box-mean filter: positions, line stores, cell chain, divide by 9.
// Depends on bm3_pkg, bm3_ram, bm3_cell, bm3_out_queue and assert_macros.svh.
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid / s_axis_tready  tdata[7:0] pixel
//  m_axis    out  m_axis_tvalid / m_axis_tready  tdata row|col|value, tlast frame_done
//  cfg       in   i_cfg_we (no wait)             i_cfg_index, i_cfg_data
//
// One pixel per cycle sustained while s_axis_tready is high. From input transfer to queue write
// an item passes line store read, cell shift and window sum register; the reciprocal multiply
// is combinational in front of the queue write, so it adds no register of its own.
// A pixel with both an interior and a border result needs two output transfers,
// so the output side sets the long-run rate when such pixels dominate.
// s_axis_tready drops only when Q_DEPTH items are in flight or queued (credit count).
// Reset: position 0/0, size 1024 x 1024, queue empty; line stores are not cleared.
`include "assert_macros.svh"

module box_mean_3x3_image_filter #(
    parameter int MAX_WIDTH = bm3_pkg::DEF_MAX_WIDTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // config write port
    input  logic                           i_cfg_we,
    input  logic [bm3_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bm3_pkg::CFG_W-1:0]      i_cfg_data,
    // pixel input
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,   // [7:0] pixel
    // result output
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [31:0]                    m_axis_tdata,   // [11:0] out_row, [21:12] out_col,
                                                           // [29:22] out_value, [31:30] zero
    output logic                           m_axis_tlast    // frame_done
);
    import bm3_pkg::*;

    localparam int CW       = $clog2(MAX_WIDTH);
    localparam int CREDIT_W = $clog2(Q_DEPTH + 1);

    // ---------------- configuration ----------------
    logic [IMG_W_W-1:0] r_img_width;
    logic [IMG_H_W-1:0] r_img_height;
    logic               cfg_hit;
    logic [31:0]        w_eff, h_eff;
    logic [CW-1:0]      w_last;
    logic [ROW_W-1:0]   h_last;

    assign cfg_hit = i_cfg_we &&
                     ((i_cfg_index == REG_IMAGE_WIDTH) || (i_cfg_index == REG_IMAGE_HEIGHT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_width  <= RESET_IMG_WIDTH;
            r_img_height <= RESET_IMG_HEIGHT;
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_IMAGE_WIDTH) begin
                r_img_width <= i_cfg_data[IMG_W_W-1:0];
            end
            if (i_cfg_index == REG_IMAGE_HEIGHT) begin
                r_img_height <= i_cfg_data[IMG_H_W-1:0];
            end
        end
    end

    // clamp sizes to the supported range
    always_comb begin
        w_eff = 32'(r_img_width);
        if (w_eff < 32'(MIN_DIM)) begin
            w_eff = 32'(MIN_DIM);
        end else if (w_eff > 32'(MAX_WIDTH)) begin
            w_eff = 32'(MAX_WIDTH);
        end
        h_eff = 32'(r_img_height);
        if (h_eff < 32'(MIN_DIM)) begin
            h_eff = 32'(MIN_DIM);
        end else if (h_eff > 32'(MAX_HEIGHT)) begin
            h_eff = 32'(MAX_HEIGHT);
        end
    end

    assign w_last = CW'(w_eff - 32'd1);
    assign h_last = ROW_W'(h_eff - 32'd1);

    // ---------------- input stage: position and flags ----------------
    logic [CREDIT_W-1:0] r_credit, n_credit;
    logic                accept;
    logic [ROW_W-1:0]    r_row, n_row;
    logic [CW-1:0]       r_col, n_col;
    logic                at_last_col, at_last_row;
    logic                is_int, is_bord;

    assign s_axis_tready = (r_credit != '0);
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign at_last_col = (r_col == w_last);
    assign at_last_row = (r_row == h_last);
    assign is_int      = (r_row >= ROW_W'(2)) && (r_col >= CW'(2));
    assign is_bord     = (r_row == '0) || at_last_row || (r_col == '0) || at_last_col;

    always_comb begin
        n_row = r_row;
        n_col = r_col;
        if (cfg_hit) begin
            // any size write restarts the frame
            n_row = '0;
            n_col = '0;
        end else if (accept) begin
            if (at_last_col) begin
                n_col = '0;
                n_row = at_last_row ? '0 : r_row + 1'b1;
            end else begin
                n_col = r_col + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

    // ---------------- pipeline registers ----------------
    logic               r_s1_valid, r_s2_valid, r_s3_valid;
    logic [DATA_W-1:0]  r_s1_pix,  r_s2_pix,  r_s3_pix;
    logic [ROW_W-1:0]   r_s1_row,  r_s2_row,  r_s3_row;
    logic [CW-1:0]      r_s1_col,  r_s2_col,  r_s3_col;
    logic               r_s1_int,  r_s2_int,  r_s3_int;
    logic               r_s1_bord, r_s2_bord, r_s3_bord;
    logic               r_s1_done, r_s2_done, r_s3_done;
    logic [SUM_W-1:0]   r_s3_sum;
    logic [SUM_W-1:0]   win_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
        end
    end

    // pipeline never stalls once an item is in; the credit count protects the queue
    always_ff @(posedge i_clk) begin
        r_s1_pix  <= s_axis_tdata;
        r_s1_row  <= r_row;
        r_s1_col  <= r_col;
        r_s1_int  <= is_int;
        r_s1_bord <= is_bord;
        r_s1_done <= at_last_row && at_last_col;

        r_s2_pix  <= r_s1_pix;
        r_s2_row  <= r_s1_row;
        r_s2_col  <= r_s1_col;
        r_s2_int  <= r_s1_int;
        r_s2_bord <= r_s1_bord;
        r_s2_done <= r_s1_done;

        r_s3_pix  <= r_s2_pix;
        r_s3_row  <= r_s2_row;
        r_s3_col  <= r_s2_col;
        r_s3_int  <= r_s2_int;
        r_s3_bord <= r_s2_bord;
        r_s3_done <= r_s2_done;
        r_s3_sum  <= win_sum;
    end

    // ---------------- line stores ----------------
    // line A: row above, line B: two rows above; read at transfer, written in the cycle after
    logic [DATA_W-1:0] line_a_rd, line_b_rd;

    bm3_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_a (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1_col),
        .i_wdata (r_s1_pix),
        .i_re    (accept),
        .i_raddr (r_col),
        .o_rdata (line_a_rd)
    );

    bm3_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_b (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1_col),
        .i_wdata (line_a_rd),
        .i_re    (accept),
        .i_raddr (r_col),
        .o_rdata (line_b_rd)
    );

    // ---------------- cell chain: newest column in cell 0 ----------------
    t_column             col_in;
    t_column             cell_col [3];
    logic [COLSUM_W-1:0] cell_sum [3];

    assign col_in.top = line_b_rd;
    assign col_in.mid = line_a_rd;
    assign col_in.bot = r_s1_pix;

    bm3_cell u_cell0 (
        .i_clk   (i_clk),
        .i_shift (r_s1_valid),
        .i_col   (col_in),
        .o_col   (cell_col[0]),
        .o_sum   (cell_sum[0])
    );

    bm3_cell u_cell1 (
        .i_clk   (i_clk),
        .i_shift (r_s1_valid),
        .i_col   (cell_col[0]),
        .o_col   (cell_col[1]),
        .o_sum   (cell_sum[1])
    );

    bm3_cell u_cell2 (
        .i_clk   (i_clk),
        .i_shift (r_s1_valid),
        .i_col   (cell_col[1]),
        .o_col   (cell_col[2]),
        .o_sum   (cell_sum[2])
    );

    // cells hold the stage-2 item's window until the next shift
    assign win_sum = SUM_W'(cell_sum[0]) + SUM_W'(cell_sum[1]) + SUM_W'(cell_sum[2]);

    // ---------------- divide by 9 and build the result pair ----------------
    logic [PROD_W-1:0] prod;
    logic [DATA_W-1:0] mean;
    logic [31:0]       col_ext, col_m1_ext;
    t_pair             pair;
    logic              push;
    logic              no_result;
    logic              q_pop;

    assign prod       = PROD_W'(r_s3_sum) * PROD_W'(RECIP_9);
    assign mean       = prod[RECIP_SHIFT +: DATA_W];
    assign col_ext    = 32'(r_s3_col);
    assign col_m1_ext = 32'(r_s3_col - 1'b1);

    always_comb begin
        pair.int_valid       = r_s3_int;
        pair.int_res.row     = r_s3_row - 1'b1;
        pair.int_res.col     = col_m1_ext[OUT_COL_W-1:0];
        pair.int_res.value   = mean;
        pair.int_res.done    = 1'b0;
        pair.bord_valid      = r_s3_bord;
        pair.bord_res.row    = r_s3_row;
        pair.bord_res.col    = col_ext[OUT_COL_W-1:0];
        pair.bord_res.value  = r_s3_pix;
        pair.bord_res.done   = r_s3_done;
    end

    assign push      = r_s3_valid && (r_s3_int || r_s3_bord);
    assign no_result = r_s3_valid && !r_s3_int && !r_s3_bord;

    // ---------------- output queue ----------------
    t_result out_res;

    bm3_out_queue #(
        .DEPTH (Q_DEPTH)
    ) u_out_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_pair   (pair),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_res    (out_res),
        .o_pop    (q_pop)
    );

    assign m_axis_tdata = {2'b00, out_res.value, out_res.col, out_res.row};
    assign m_axis_tlast = out_res.done;

    // ---------------- credits: one per item in flight or queued ----------------
    assign n_credit = r_credit + CREDIT_W'(q_pop) + CREDIT_W'(no_result) - CREDIT_W'(accept);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credit <= CREDIT_W'(Q_DEPTH);
        end else begin
            r_credit <= n_credit;
        end
    end

    `ASSERT_CLK(a_credit_bound, r_credit <= CREDIT_W'(Q_DEPTH),
        "credit count above queue depth")
    `ASSERT_CLK(a_cfg_restart, cfg_hit |=> ((r_row == '0) && (r_col == '0)),
        "size write did not restart the frame")
    `ASSERT_CLK(a_sum_range, (r_s3_valid && r_s3_int) |-> (r_s3_sum <= MAX_SUM),
        "window sum out of range")

endmodule
